FILE: hw/rtl/dgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgt_pkg: shared types and constants of the depth grid triangulator
// Register indexes, reset values, queue status and entry sizing.
// ----------------------------------------------------------------------------
package dgt_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 1024;
  localparam int MAX_HEIGHT_DEFAULT = 1024;
  localparam int COORD_BITS_DEFAULT = 24;

  localparam int SIZE_BITS      = 11;
  localparam int THRESH_BITS    = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int INDEX_BITS     = 20;
  localparam int DIFF_BITS      = 16;
  localparam int MIN_SIZE       = 2;

  localparam logic [SIZE_BITS-1:0]   GRID_WIDTH_RESET     = 11'd640;
  localparam logic [SIZE_BITS-1:0]   GRID_HEIGHT_RESET    = 11'd480;
  localparam logic [THRESH_BITS-1:0] EDGE_THRESHOLD_RESET = 16'd655;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_index_t;

  // queue depth must be a power of two (pointers wrap naturally)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                   empty;
    logic [QCOUNT_BITS-1:0] space;
  } queue_status_t;

  function automatic int vertex_bits(input int cb);
    return 3 * cb + 1;
  endfunction

  // cur, left, top-left, top-right vertices, column, row, width, cell flag
  function automatic int entry_bits(input int mw, input int mh, input int cb);
    return 4 * vertex_bits(cb) + $clog2(mw) + $clog2(mh) + $clog2(mw + 1) + 1;
  endfunction

endpackage

FILE: hw/rtl/dgt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgt_queue: cell word queue
// Short register FIFO between the raster front end and the triangle back end.
// ----------------------------------------------------------------------------
module dgt_queue #(
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         head,
  output dgt_pkg::queue_status_t   status
);

  logic [WIDTH-1:0]                  store [dgt_pkg::QUEUE_DEPTH];
  logic [dgt_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [dgt_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [dgt_pkg::QCOUNT_BITS-1:0]   count;
  logic                              do_pop;

  assign do_pop = pop && (count != '0);
  assign head   = store[rd_ptr];

  always_comb begin
    status.empty = (count == '0);
    status.space = dgt_pkg::QCOUNT_BITS'(dgt_pkg::QUEUE_DEPTH) - count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/dgt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgt_front: raster front end
// Tracks column and row, keeps the previous row in a line buffer and the left
// vertex in a register, and hands each vertex with its cell corners onward.
// ----------------------------------------------------------------------------
module dgt_front #(
  parameter int MAX_WIDTH  = dgt_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = dgt_pkg::MAX_HEIGHT_DEFAULT,
  parameter int COORD_BITS = dgt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [dgt_pkg::vertex_bits(COORD_BITS)-1:0] in_vertex,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]              grid_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]             grid_h,
  input  dgt_pkg::queue_status_t                      q_status,
  output logic                                        push,
  output logic [dgt_pkg::entry_bits(MAX_WIDTH, MAX_HEIGHT, COORD_BITS)-1:0] push_data
);

  localparam int VW = dgt_pkg::vertex_bits(COORD_BITS);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [VW-1:0] line_buf [MAX_WIDTH];
  logic [VW-1:0] rdata;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [VW-1:0] left;
  logic [VW-1:0] top_last;

  logic          s1_valid;
  logic [VW-1:0] s1_cur;
  logic [VW-1:0] s1_left;
  logic [CW-1:0] s1_c;
  logic [RW-1:0] s1_r;
  logic [WW-1:0] s1_w;
  logic          s1_cell;

  logic          pend_valid;
  logic [CW-1:0] pend_addr;
  logic [VW-1:0] pend_data;

  logic          accept;
  logic          wrap_c;
  logic [RW:0]   r_pre;
  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [CW:0]   c_inc;
  logic [RW:0]   r_inc;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;

  // the word accepted now lands in s1 next cycle and is pushed from there
  always_comb begin
    if (s1_valid) begin
      in_stall = pend_valid || (q_status.space < dgt_pkg::QCOUNT_BITS'(2));
    end else begin
      in_stall = pend_valid || (q_status.space == '0);
    end
  end

  assign accept = in_valid && !in_stall;

  // a size change between frames may leave the counters out of range
  always_comb begin
    wrap_c   = WW'(col) >= grid_w;
    c        = wrap_c ? '0 : col;
    r_pre    = (RW+1)'(row) + (RW+1)'(wrap_c);
    r        = (r_pre >= (RW+1)'(grid_h)) ? '0 : r_pre[RW-1:0];
    c_inc    = (CW+1)'(c) + (CW+1)'(1);
    r_inc    = (RW+1)'(r) + (RW+1)'(1);
    last_col = c_inc >= (CW+1)'(grid_w);
    last_row = r_inc >= (RW+1)'(grid_h);
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : r_inc[RW-1:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r;
    end
  end

  // left vertex retires to its column; the last column is written in the next
  // cycle so the read of the old top-right is not disturbed
  always_comb begin
    mem_we    = pend_valid || (accept && (c != '0));
    mem_waddr = pend_valid ? pend_addr : c - 1'b1;
    mem_wdata = pend_valid ? pend_data : left;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= line_buf[c];
    end
    if (mem_we) begin
      line_buf[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      s1_valid   <= accept;
      pend_valid <= accept && last_col;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left      <= in_vertex;
      s1_cur    <= in_vertex;
      s1_left   <= left;
      s1_c      <= c;
      s1_r      <= r;
      s1_w      <= grid_w;
      s1_cell   <= (c != '0) && (r != '0);
      pend_addr <= c;
      pend_data <= in_vertex;
    end
    // old top of column c-1 was read by the previous word
    if (s1_valid) begin
      top_last <= rdata;
    end
  end

  assign push      = s1_valid;
  assign push_data = {s1_cell, s1_w, s1_r, s1_c, rdata, top_last, s1_left, s1_cur};

endmodule

FILE: hw/rtl/dgt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgt_back: triangle back end
// Edge length tests, vertex index math and triangle output with skid slots.
// ----------------------------------------------------------------------------
module dgt_back #(
  parameter int MAX_WIDTH  = dgt_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = dgt_pkg::MAX_HEIGHT_DEFAULT,
  parameter int COORD_BITS = dgt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [dgt_pkg::entry_bits(MAX_WIDTH, MAX_HEIGHT, COORD_BITS)-1:0] head,
  input  dgt_pkg::queue_status_t                  q_status,
  output logic                                    pop,
  input  logic [dgt_pkg::THRESH_BITS-1:0]         threshold,
  output logic                                    tri_valid,
  input  logic                                    tri_stall,
  output logic [dgt_pkg::INDEX_BITS-1:0]          corner_a,
  output logic [dgt_pkg::INDEX_BITS-1:0]          corner_b,
  output logic [dgt_pkg::INDEX_BITS-1:0]          corner_c,
  output logic                                    last_of_cell
);

  localparam int VW  = dgt_pkg::vertex_bits(COORD_BITS);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = dgt_pkg::entry_bits(MAX_WIDTH, MAX_HEIGHT, COORD_BITS);
  localparam int PW  = RW + WW;
  localparam int DB  = dgt_pkg::DIFF_BITS;
  localparam int IB  = dgt_pkg::INDEX_BITS;
  localparam int SQB = 2 * DB;
  localparam int SUMB = SQB + 2;
  localparam int AW  = (COORD_BITS + 1 > DB + 1) ? COORD_BITS + 1 : DB + 1;
  localparam int VPOS = 3 * COORD_BITS;
  localparam int C_OFS = 4 * VW;
  localparam int R_OFS = C_OFS + CW;
  localparam int W_OFS = R_OFS + RW;

  typedef struct packed {
    logic [IB-1:0] a;
    logic [IB-1:0] b;
    logic [IB-1:0] c;
  } tri_t;

  function automatic logic [AW-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                             input logic [COORD_BITS-1:0] b);
    logic signed [AW-1:0] sa;
    logic signed [AW-1:0] sb;
    logic signed [AW-1:0] d;
    sa = AW'($signed(a));
    sb = AW'($signed(b));
    d  = sa - sb;
    return d[AW-1] ? $unsigned(-d) : $unsigned(d);
  endfunction

  logic [VW-1:0] cur, lft, tl, tr;
  logic [CW-1:0] e_c;
  logic [RW-1:0] e_r;
  logic [WW-1:0] e_w;
  logic          e_cell;
  logic [VW-1:0] ea [4];
  logic [VW-1:0] eb [4];
  logic [AW-1:0] ad [4][3];
  logic [3:0]    over_c;

  logic          adv;
  logic          take;
  logic [1:0]    cnt;
  tri_t          slot0;
  tri_t          slot1;

  logic          p1_v;
  logic [DB-1:0] p1_d [4][3];
  logic [3:0]    p1_over;
  logic [1:0]    p1_tv;
  logic [IB-1:0] p1_base;
  logic [CW-1:0] p1_c;
  logic [WW-1:0] p1_w;

  logic           p2_v;
  logic [SQB-1:0] p2_sq [4][3];
  logic [3:0]     p2_over;
  logic [1:0]     p2_tv;
  logic [IB-1:0]  p2_ibl, p2_ibr, p2_itl, p2_itr;

  logic [SQB-1:0]  thr_sq;
  logic [SUMB-1:0] sum [4];
  logic [3:0]      short_e;
  logic            t1, t2;

  always_comb begin
    cur    = head[VW-1:0];
    lft    = head[2*VW-1:VW];
    tl     = head[3*VW-1:2*VW];
    tr     = head[4*VW-1:3*VW];
    e_c    = head[C_OFS +: CW];
    e_r    = head[R_OFS +: RW];
    e_w    = head[W_OFS +: WW];
    e_cell = head[EW-1];
    // tested edges: top pair and left pair for the first triangle,
    // bottom pair and right pair for the second
    ea[0] = tl;  eb[0] = tr;
    ea[1] = tl;  eb[1] = lft;
    ea[2] = lft; eb[2] = cur;
    ea[3] = tr;  eb[3] = cur;
    for (int e = 0; e < 4; e++) begin
      for (int k = 0; k < 3; k++) begin
        ad[e][k] = abs_diff(ea[e][k*COORD_BITS +: COORD_BITS],
                            eb[e][k*COORD_BITS +: COORD_BITS]);
      end
      over_c[e] = (|ad[e][0][AW-1:DB]) | (|ad[e][1][AW-1:DB]) | (|ad[e][2][AW-1:DB]);
    end
  end

  assign take = tri_valid && !tri_stall;
  assign adv  = (cnt == 2'd0) || ((cnt == 2'd1) && take);
  assign pop  = adv && !q_status.empty;

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      sum[e] = SUMB'(p2_sq[e][0]) + SUMB'(p2_sq[e][1]) + SUMB'(p2_sq[e][2]);
      short_e[e] = !p2_over[e] && (sum[e] < SUMB'(thr_sq));
    end
    t1 = p2_tv[0] && short_e[0] && short_e[1];
    t2 = p2_tv[1] && short_e[2] && short_e[3];
  end

  always_ff @(posedge clk) begin
    thr_sq <= {{DB{1'b0}}, threshold} * {{DB{1'b0}}, threshold};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (adv) begin
        p1_v <= pop;
        p2_v <= p1_v;
      end
      if (take && (cnt == 2'd2)) begin
        cnt <= 2'd1;
      end else if (adv) begin
        cnt <= p2_v ? {t1 && t2, t1 ^ t2} : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 4; e++) begin
        for (int k = 0; k < 3; k++) begin
          p1_d[e][k]  <= ad[e][k][DB-1:0];
          p2_sq[e][k] <= {{DB{1'b0}}, p1_d[e][k]} * {{DB{1'b0}}, p1_d[e][k]};
        end
      end
      p1_over <= over_c;
      p1_tv[0] <= e_cell && tl[VPOS] && lft[VPOS] && tr[VPOS];
      p1_tv[1] <= e_cell && lft[VPOS] && cur[VPOS] && tr[VPOS];
      p1_base <= IB'(PW'(e_r) * PW'(e_w));
      p1_c    <= e_c;
      p1_w    <= e_w;

      p2_over <= p1_over;
      p2_tv   <= p1_tv;
      p2_ibl  <= p1_base + IB'(p1_c) - IB'(1);
      p2_ibr  <= p1_base + IB'(p1_c);
      p2_itl  <= p1_base + IB'(p1_c) - IB'(1) - IB'(p1_w);
      p2_itr  <= p1_base + IB'(p1_c) - IB'(p1_w);
    end

    if (take && (cnt == 2'd2)) begin
      slot0 <= slot1;
    end else if (adv && p2_v) begin
      slot0 <= t1 ? tri_t'{a: p2_itl, b: p2_ibl, c: p2_itr}
                  : tri_t'{a: p2_ibl, b: p2_ibr, c: p2_itr};
      slot1 <= tri_t'{a: p2_ibl, b: p2_ibr, c: p2_itr};
    end
  end

  assign tri_valid    = (cnt != 2'd0);
  assign last_of_cell = (cnt == 2'd1);
  assign corner_a     = slot0.a;
  assign corner_b     = slot0.b;
  assign corner_c     = slot0.c;

endmodule

FILE: hw/rtl/depth_grid_triangulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_grid_triangulator_core: organized point cloud to triangle indices
// Vertices enter in raster order on the vertex channel (vertex_valid /
// vertex_stall, pos_x/y/z, point_valid). Triangles leave on the tri channel
// (tri_valid / tri_stall) as three vertex indices, last_of_cell marking the
// final triangle of a vertex. Grid size and edge threshold are written through
// cfg_write / cfg_index / cfg_data while the block is idle.
// Throughput: one vertex per cycle while the queue has room; the input also
// stalls at each row end for the line buffer write of the last column. The
// triangle port drains one triangle per cycle while tri_stall is low, and a
// cell that yields both triangles sends them in turn through the output slots.
// A 4-word queue separates the front end from the edge-test pipeline; when the
// receiver stalls, the back end holds and the queue fills, then vertex_stall
// rises. Reset clears counters and pipeline state and loads the default
// configuration; the line buffer is not cleared (each entry is written in the
// first row before it is read).
// ----------------------------------------------------------------------------
module depth_grid_triangulator_core #(
  parameter int MAX_WIDTH  = dgt_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = dgt_pkg::MAX_HEIGHT_DEFAULT,
  parameter int COORD_BITS = dgt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  vertex_valid,
  output logic                                  vertex_stall,
  input  logic signed [COORD_BITS-1:0]          pos_x,
  input  logic signed [COORD_BITS-1:0]          pos_y,
  input  logic signed [COORD_BITS-1:0]          pos_z,
  input  logic                                  point_valid,
  output logic                                  tri_valid,
  input  logic                                  tri_stall,
  output logic [dgt_pkg::INDEX_BITS-1:0]        corner_a,
  output logic [dgt_pkg::INDEX_BITS-1:0]        corner_b,
  output logic [dgt_pkg::INDEX_BITS-1:0]        corner_c,
  output logic                                  last_of_cell,
  input  logic                                  cfg_write,
  input  logic [dgt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dgt_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int EW = dgt_pkg::entry_bits(MAX_WIDTH, MAX_HEIGHT, COORD_BITS);

  logic [dgt_pkg::SIZE_BITS-1:0]   grid_width;
  logic [dgt_pkg::SIZE_BITS-1:0]   grid_height;
  logic [dgt_pkg::THRESH_BITS-1:0] edge_threshold;
  logic [WW-1:0]                   w_eff;
  logic [HW-1:0]                   h_eff;

  logic                            push;
  logic [EW-1:0]                   push_data;
  logic                            pop;
  logic [EW-1:0]                   head;
  dgt_pkg::queue_status_t          q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= dgt_pkg::GRID_WIDTH_RESET;
      grid_height    <= dgt_pkg::GRID_HEIGHT_RESET;
      edge_threshold <= dgt_pkg::EDGE_THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (dgt_pkg::reg_index_t'(cfg_index))
        dgt_pkg::REG_GRID_WIDTH:     grid_width     <= cfg_data[dgt_pkg::SIZE_BITS-1:0];
        dgt_pkg::REG_GRID_HEIGHT:    grid_height    <= cfg_data[dgt_pkg::SIZE_BITS-1:0];
        dgt_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes are used clamped to the supported range
  always_comb begin
    if (int'(grid_width) < dgt_pkg::MIN_SIZE) begin
      w_eff = WW'(dgt_pkg::MIN_SIZE);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width);
    end
    if (int'(grid_height) < dgt_pkg::MIN_SIZE) begin
      h_eff = HW'(dgt_pkg::MIN_SIZE);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height);
    end
  end

  dgt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex_valid),
    .in_stall  (vertex_stall),
    .in_vertex ({point_valid, pos_z, pos_y, pos_x}),
    .grid_w    (w_eff),
    .grid_h    (h_eff),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  dgt_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  dgt_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .threshold    (edge_threshold),
    .tri_valid    (tri_valid),
    .tri_stall    (tri_stall),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .last_of_cell (last_of_cell)
  );

`ifndef SYNTHESIS
  // the credit check in the front end must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_status.space != '0))
    else $error("cell queue overflow");

  // a first triangle of two is always followed by its partner
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (tri_valid && !last_of_cell) |=> tri_valid)
    else $error("second triangle of cell missing");

  // every triangle has one horizontal neighbor pair: tl/tr or bl/br
  a_corner_shape: assert property (@(posedge clk) disable iff (rst)
    tri_valid |-> ((corner_c == corner_a + 20'd1) || (corner_b == corner_a + 20'd1)))
    else $error("triangle corners do not form a grid cell half");
`endif

endmodule

FILE: bench/depth_grid_triangulator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_grid_triangulator_core_tb: self-checking bench for the grid triangulator
// Streams raster-order vertices with bursty sender gaps and a patterned
// receiver stall. A software mirror of the row buffer, counters and edge tests
// predicts the triangles of each vertex; every triangle word is compared in
// order. Directed cells, threshold limits, size clamps, largest sizes,
// mid-frame resizes, then random clustered grids with noise.
// ----------------------------------------------------------------------------
module depth_grid_triangulator_core_tb;

  localparam int CB             = dgt_pkg::COORD_BITS_DEFAULT;
  localparam int MAX_W          = dgt_pkg::MAX_WIDTH_DEFAULT;
  localparam int MAX_H          = dgt_pkg::MAX_HEIGHT_DEFAULT;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 640;
  localparam int MAXC           = 8388607;
  localparam int MINC           = -8388608;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 valid;
  } gvert_t;

  typedef struct {
    logic [dgt_pkg::INDEX_BITS-1:0] ia;
    logic [dgt_pkg::INDEX_BITS-1:0] ib;
    logic [dgt_pkg::INDEX_BITS-1:0] ic;
    logic                           last;
  } face_t;

  logic                               clk;
  logic                               rst          = 1'b1;
  logic                               vertex_valid = 1'b0;
  logic                               vertex_stall;
  logic signed [CB-1:0]               pos_x        = '0;
  logic signed [CB-1:0]               pos_y        = '0;
  logic signed [CB-1:0]               pos_z        = '0;
  logic                               point_valid  = 1'b0;
  logic                               tri_valid;
  logic                               tri_stall    = 1'b0;
  logic [dgt_pkg::INDEX_BITS-1:0]     corner_a;
  logic [dgt_pkg::INDEX_BITS-1:0]     corner_b;
  logic [dgt_pkg::INDEX_BITS-1:0]     corner_c;
  logic                               last_of_cell;
  logic                               cfg_write    = 1'b0;
  dgt_pkg::reg_index_t                cfg_index    = dgt_pkg::REG_GRID_WIDTH;
  logic [dgt_pkg::CFG_DATA_BITS-1:0]  cfg_data     = '0;

  depth_grid_triangulator_core dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .point_valid  (point_valid),
    .tri_valid    (tri_valid),
    .tri_stall    (tri_stall),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .last_of_cell (last_of_cell),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mirror of the block: row buffer, left vertex, counters, registers
  gvert_t                          prev_row [MAX_W];
  gvert_t                          left_pt;
  int unsigned                     col_n, row_n, rows_written;
  logic [dgt_pkg::SIZE_BITS-1:0]   grid_w_reg = dgt_pkg::GRID_WIDTH_RESET;
  logic [dgt_pkg::SIZE_BITS-1:0]   grid_h_reg = dgt_pkg::GRID_HEIGHT_RESET;
  logic [dgt_pkg::THRESH_BITS-1:0] edge_thr   = dgt_pkg::EDGE_THRESHOLD_RESET;
  face_t                           face_queue [$];

  int n_errors, n_vertices, n_faces, n_both, n_writes;
  int burst_left;
  logic drain_mode = 1'b0;

  // cluster generator settings
  int anc_x, anc_y, anc_z, spread, invalid_pct, wild_pct;

  initial begin
    left_pt = '{x: '0, y: '0, z: '0, valid: 1'b0};
    col_n = 0;
    row_n = 0;
    rows_written = 0;
  end

  task automatic report_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    n_errors++;
  endtask

  function automatic int unsigned eff_size(input logic [dgt_pkg::SIZE_BITS-1:0] v,
                                           input int unsigned hi);
    if (v < dgt_pkg::MIN_SIZE) return dgt_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit edge_short(input gvert_t p, input gvert_t q);
    longint dx, dy, dz, lim;
    dx  = longint'(p.x) - longint'(q.x);
    dy  = longint'(p.y) - longint'(q.y);
    dz  = longint'(p.z) - longint'(q.z);
    lim = longint'(edge_thr);
    return dx * dx + dy * dy + dz * dz < lim * lim;
  endfunction

  function automatic logic [dgt_pkg::INDEX_BITS-1:0] vertex_index(input int unsigned r,
      input int unsigned c, input int unsigned w);
    return dgt_pkg::INDEX_BITS'(r * w + c);
  endfunction

  // advance the mirror by one vertex and queue the triangles it completes
  task automatic triangulate_vertex(input gvert_t cur);
    int unsigned w, h, c, r;
    gvert_t tl, tr;
    bit got1, got2;
    w = eff_size(grid_w_reg, MAX_W);
    h = eff_size(grid_h_reg, MAX_H);
    if (col_n >= w) begin
      col_n = 0;
      row_n++;
    end
    if (row_n >= h) row_n = 0;
    c = col_n;
    r = row_n;
    if (c > 0) begin
      if (r > 0) begin
        if (c >= rows_written) report_error("stimulus reads an unwritten row buffer entry");
        tl = prev_row[c-1];
        tr = prev_row[c];
        got1 = tl.valid && left_pt.valid && tr.valid &&
               edge_short(tl, tr) && edge_short(tl, left_pt);
        got2 = left_pt.valid && cur.valid && tr.valid &&
               edge_short(left_pt, cur) && edge_short(tr, cur);
        if (got1)
          face_queue.push_back('{ia: vertex_index(r-1, c-1, w), ib: vertex_index(r, c-1, w),
                                 ic: vertex_index(r-1, c, w), last: !got2});
        if (got2)
          face_queue.push_back('{ia: vertex_index(r, c-1, w), ib: vertex_index(r, c, w),
                                 ic: vertex_index(r-1, c, w), last: 1'b1});
        if (got1 && got2) n_both++;
      end
      prev_row[c-1] = left_pt;
      if (c > rows_written) rows_written = c;
    end
    if (c + 1 >= w) begin
      prev_row[c] = cur;
      if (c + 1 > rows_written) rows_written = c + 1;
    end
    left_pt = cur;
    col_n = c + 1;
    if (col_n >= w) begin
      col_n = 0;
      row_n = (r + 1 >= h) ? 0 : r + 1;
    end
  endtask

  function automatic gvert_t pt(input int x, input int y, input int z, input bit ok);
    gvert_t v;
    v.x = CB'(x);
    v.y = CB'(y);
    v.z = CB'(z);
    v.valid = ok;
    return v;
  endfunction

  function automatic int jitter();
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic gvert_t make_vertex();
    gvert_t v;
    if ($urandom_range(99) < wild_pct)
      v = pt($urandom, $urandom, $urandom, 1'b1);
    else
      v = pt(anc_x + jitter(), anc_y + jitter(), anc_z + jitter(), 1'b1);
    v.valid = $urandom_range(99) >= invalid_pct;
    return v;
  endfunction

  task automatic aim_cluster(input int spr, input int inv, input int wild);
    anc_x = $urandom_range(16777215) - 8388608;
    anc_y = $urandom_range(16777215) - 8388608;
    anc_z = $urandom_range(16777215) - 8388608;
    // now and then sit on the coordinate limits so offsets wrap around
    if ($urandom_range(3) == 0) anc_z = $urandom_range(1) ? MAXC : MINC;
    spread = (spr < 1) ? 1 : spr;
    invalid_pct = inv;
    wild_pct = wild;
  endtask

  task automatic send_vertex(input gvert_t v);
    int gap;
    if (drain_mode) drain_mode <= 1'b0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        vertex_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    triangulate_vertex(v);
    vertex_valid <= 1'b1;
    pos_x        <= v.x;
    pos_y        <= v.y;
    pos_z        <= v.z;
    point_valid  <= v.valid;
    do @(posedge clk); while (vertex_stall);
    n_vertices++;
  endtask

  task automatic send_cluster(input int count);
    repeat (count) send_vertex(make_vertex());
  endtask

  // stop input, let the stall go, and wait for every triangle plus pipeline tail
  task automatic settle_block();
    vertex_valid <= 1'b0;
    drain_mode   <= 1'b1;
    burst_left = 0;
    @(posedge clk);
    while (face_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dgt_pkg::reg_index_t idx,
                           input logic [dgt_pkg::CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      dgt_pkg::REG_GRID_WIDTH:     grid_w_reg = data[dgt_pkg::SIZE_BITS-1:0];
      dgt_pkg::REG_GRID_HEIGHT:    grid_h_reg = data[dgt_pkg::SIZE_BITS-1:0];
      dgt_pkg::REG_EDGE_THRESHOLD: edge_thr   = data[dgt_pkg::THRESH_BITS-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // 2x2 frames under the reset threshold: coordinate limits, invalid corner,
  // huge difference, edge exactly at the threshold
  task automatic test_single_cells();
    settle_block();
    write_reg(dgt_pkg::REG_GRID_WIDTH, 16'd2);
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'd2);
    repeat (4) send_vertex(pt(MAXC, MAXC, MAXC, 1'b1));
    send_vertex(pt(MINC, MINC, MINC, 1'b1));
    send_vertex(pt(MINC + 200, MINC, MINC + 100, 1'b1));
    send_vertex(pt(MINC, MINC + 300, MINC, 1'b1));
    send_vertex(pt(MINC + 200, MINC + 300, MINC + 150, 1'b1));
    send_vertex(pt(0, 0, 0, 1'b0));
    repeat (3) send_vertex(pt(0, 0, 0, 1'b1));
    repeat (3) send_vertex(pt(0, 0, 0, 1'b1));
    send_vertex(pt(MINC, 0, 0, 1'b1));
    send_vertex(pt(0, 0, 0, 1'b1));
    send_vertex(pt(655, 0, 0, 1'b1));
    send_vertex(pt(0, 0, 0, 1'b1));
    send_vertex(pt(400, 0, 0, 1'b1));
  endtask

  task automatic test_threshold_limits();
    settle_block();
    write_reg(dgt_pkg::REG_EDGE_THRESHOLD, 16'd0);
    repeat (4) send_vertex(pt(0, 0, 0, 1'b1));
    settle_block();
    write_reg(dgt_pkg::REG_EDGE_THRESHOLD, 16'hFFFF);
    send_vertex(pt(0, 0, 0, 1'b1));
    send_vertex(pt(37000, -37000, 0, 1'b1));
    send_vertex(pt(0, 0, 65535, 1'b1));
    send_vertex(pt(37000, -37000, 30000, 1'b1));
  endtask

  task automatic test_size_clamp();
    settle_block();
    write_reg(dgt_pkg::REG_GRID_WIDTH, 16'd0);
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'd1);
    write_reg(dgt_pkg::REG_EDGE_THRESHOLD, 16'd2000);
    aim_cluster(500, 0, 0);
    send_cluster(8);
  endtask

  // widest row with upper data bits set: the first stretch of the row must
  // yield no cell; it also fills the row buffer for the later tests
  task automatic test_widest_row();
    settle_block();
    write_reg(dgt_pkg::REG_GRID_WIDTH, 16'hFC00);
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'hF801);
    write_reg(dgt_pkg::REG_EDGE_THRESHOLD, 16'd1500);
    aim_cluster(400, 3, 1);
    send_cluster(60);
  endtask

  task automatic test_resize_mid_frame();
    settle_block();
    write_reg(dgt_pkg::REG_GRID_WIDTH, 16'd4);
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'd5);
    aim_cluster(400, 0, 0);
    send_cluster(9);
    settle_block();
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'd3);
    send_cluster(6);
    settle_block();
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'd2);
    send_cluster(6);
    settle_block();
    write_reg(dgt_pkg::REG_GRID_WIDTH, 16'd9);
    send_cluster(12);
  endtask

  // two columns, height clamped to the largest, rows well past a small frame
  task automatic test_tallest_frame();
    settle_block();
    write_reg(dgt_pkg::REG_GRID_WIDTH, 16'd2);
    write_reg(dgt_pkg::REG_GRID_HEIGHT, 16'hFFFF);
    aim_cluster(500, 4, 1);
    send_cluster(40);
  endtask

  task automatic test_random_grids();
    int sent, count, pick;
    logic [dgt_pkg::CFG_DATA_BITS-1:0] w, h, t;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      pick = $urandom_range(9);
      w = (pick == 0) ? $urandom_range(1) : (pick < 3) ? $urandom_range(48, 13)
                                                        : $urandom_range(12, 2);
      h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
      case ($urandom_range(7))
        0:       t = $urandom_range(65535);
        1:       t = 16'd0;
        2:       t = 16'hFFFF;
        default: t = $urandom_range(3000, 1);
      endcase
      if ($urandom_range(1)) write_reg(dgt_pkg::REG_GRID_WIDTH, w);
      if ($urandom_range(1)) write_reg(dgt_pkg::REG_GRID_HEIGHT, h);
      write_reg(dgt_pkg::REG_EDGE_THRESHOLD, t);
      aim_cluster(int'(t) * $urandom_range(60, 20) / 100, $urandom_range(20),
                  $urandom_range(10));
      count = $urandom_range(90, 30);
      send_cluster(count);
      sent += count;
    end
  endtask

  // receiver stall: open stretches mixed with choppy stall runs
  int stall_left = 0;
  logic stall_bit = 1'b0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(3) == 0) begin
        stall_bit  = 1'b0;
        stall_left = $urandom_range(60, 20);
      end else begin
        stall_bit  = $urandom_range(1);
        stall_left = $urandom_range(8, 1);
      end
    end
    stall_left--;
    tri_stall <= drain_mode ? 1'b0 : stall_bit;
  end

  always @(posedge clk) begin
    face_t want;
    if (!rst && tri_valid && !tri_stall) begin
      if (face_queue.size() == 0) begin
        report_error($sformatf("triangle %0d %0d %0d with none expected",
                               corner_a, corner_b, corner_c));
      end else begin
        want = face_queue.pop_front();
        if (corner_a !== want.ia)
          report_error($sformatf("corner_a %0d, want %0d", corner_a, want.ia));
        if (corner_b !== want.ib)
          report_error($sformatf("corner_b %0d, want %0d", corner_b, want.ib));
        if (corner_c !== want.ic)
          report_error($sformatf("corner_c %0d, want %0d", corner_c, want.ic));
        if (last_of_cell !== want.last)
          report_error($sformatf("last_of_cell %0b, want %0b", last_of_cell, want.last));
      end
      n_faces++;
    end
  end

  // counts cycles with work pending but no word moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (vertex_valid && !vertex_stall) || (tri_valid && !tri_stall) ||
        (!vertex_valid && face_queue.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d triangles outstanding",
               idle_cycles, face_queue.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_cells();
    test_threshold_limits();
    test_size_clamp();
    test_widest_row();
    test_resize_mid_frame();
    test_tallest_frame();
    test_random_grids();
    settle_block();
    if (face_queue.size() != 0)
      report_error($sformatf("%0d triangles never arrived", face_queue.size()));
    $display("run covered %0d vertices, %0d triangles checked (%0d cells with both)",
             n_vertices, n_faces, n_both);
    $display("%0d register writes, %0d mismatches", n_writes, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
